/* rtl/core/lpcf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_pkg
// Shared types and constants of the local peak clip filter.
// ----------------------------------------------------------------------------
package lpcf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int PIXEL_BITS  = 8;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   addr_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // input word kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // access of one line store in one cycle
   typedef struct packed {
      logic      en;
      logic      we;
      addr_type  addr;
      pixel_type wdata;
   } ram_req_type;

   // what the filter stage needs to know about one word
   typedef struct packed {
      logic      emit;
      logic      first_col;
      logic      has_left;
      logic      has_right;
      logic      has_up;
      logic      has_down;
      logic      capture;
      logic      row_end;
      logic      frame_end;
      logic      sel;
      pixel_type down;
   } item_type;

endpackage

/* rtl/core/lpcf_line_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_line_ram
// Single-port line store, read-first, registered read data.
// ----------------------------------------------------------------------------
module lpcf_line_ram (
   input  logic                 clock,
   input  lpcf_pkg::ram_req_type req,
   output lpcf_pkg::pixel_type   rdata
);
   import lpcf_pkg::*;

   pixel_type line_ff [MAX_WIDTH];
   pixel_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         rdata_ff <= line_ff[req.addr];
         if (req.we) begin
            line_ff[req.addr] <= req.wdata;
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/lpcf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_ctrl
// Configuration registers, raster counters and line store addressing.
// ----------------------------------------------------------------------------
module lpcf_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lpcf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lpcf_pkg::CSR_BITS-1:0]        csr_wdata,
   input  logic                                 accept,
   input  logic                                 req_op,
   input  lpcf_pkg::pixel_type                  req_pixel,
   output lpcf_pkg::ram_req_type                ram_a_req,
   output lpcf_pkg::ram_req_type                ram_b_req,
   output logic                                 item_valid,
   output lpcf_pkg::item_type                   item
);
   import lpcf_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [WIDTH_BITS-1:0]  drain_ff, drain_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic                   sel_ff, sel_in;

   logic [WIDTH_BITS-1:0]  w_eff;
   logic [HEIGHT_BITS-1:0] h_eff;
   logic                   is_pix;
   logic [WIDTH_BITS:0]    col_c;
   logic                   last;
   logic                   pass;
   logic                   go;
   addr_type               older_addr;
   addr_type               newer_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         height_ff <= HEIGHT_BITS'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;

      is_pix = (req_op == OP_PIXEL);
      col_c  = is_pix ? {{(WIDTH_BITS+1-COL_BITS){1'b0}}, col_ff} : {1'b0, drain_ff};
      last   = (col_c + (WIDTH_BITS+1)'(1)) >= {1'b0, w_eff};
      pass   = is_pix ? (row_ff < h_eff) : (row_ff >= h_eff);
      go     = accept & pass;

      older_addr = col_c[COL_BITS-1:0];
      newer_addr = col_c[COL_BITS-1:0] + COL_BITS'(1);

      // sel_ff high: middle store (b) holds the older row
      ram_a_req.en    = go;
      ram_a_req.we    = go & is_pix & ~sel_ff;
      ram_a_req.addr  = sel_ff ? newer_addr : older_addr;
      ram_a_req.wdata = req_pixel;
      ram_b_req.en    = go;
      ram_b_req.we    = go & is_pix & sel_ff;
      ram_b_req.addr  = sel_ff ? older_addr : newer_addr;
      ram_b_req.wdata = req_pixel;

      item_valid      = go;
      item.emit       = is_pix ? (row_ff != '0) : 1'b1;
      item.first_col  = (col_c == '0);
      item.has_left   = (col_c != '0);
      item.has_right  = ~last;
      item.has_up     = (row_ff > HEIGHT_BITS'(1));
      item.has_down   = is_pix;
      item.capture    = is_pix & (col_c == '0);
      item.row_end    = last;
      item.frame_end  = ~is_pix & last;
      item.sel        = sel_ff;
      item.down       = req_pixel;

      col_in   = col_ff;
      drain_in = drain_ff;
      row_in   = row_ff;
      sel_in   = sel_ff;
      if (go) begin
         if (is_pix) begin
            if (last) begin
               col_in = '0;
               row_in = row_ff + HEIGHT_BITS'(1);
               sel_in = ~sel_ff;
            end else begin
               col_in = col_ff + COL_BITS'(1);
            end
         end else if (last) begin
            col_in   = '0;
            drain_in = '0;
            row_in   = '0;
            sel_in   = 1'b0;
         end else begin
            drain_in = drain_ff + WIDTH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         drain_ff <= '0;
         row_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         drain_ff <= drain_in;
         row_ff   <= row_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

/* rtl/core/lpcf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcf_window
// Neighbor window over the newer row, peak clip and output register.
// ----------------------------------------------------------------------------
module lpcf_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  lpcf_pkg::item_type  item,
   input  lpcf_pkg::pixel_type ram_a_rdata,
   input  lpcf_pkg::pixel_type ram_b_rdata,
   output logic                s1_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output lpcf_pkg::pixel_type rsp_pixel,
   output logic                rsp_row_end,
   output logic                rsp_frame_end
);
   import lpcf_pkg::*;

   logic      s1_valid_ff;
   item_type  s1_item_ff;
   pixel_type row0_ff;
   pixel_type ctr_ff;
   pixel_type lft_ff;
   logic      rsp_valid_ff;
   pixel_type rsp_pixel_ff;
   logic      rsp_row_end_ff;
   logic      rsp_frame_end_ff;

   pixel_type newer_rd, older_rd, center, best, max_a, max_b;
   pixel_type nb_up, nb_dn, nb_lf, nb_rt, result;
   logic      peak;
   logic      consume;

   always_comb begin
      newer_rd = s1_item_ff.sel ? ram_a_rdata : ram_b_rdata;
      older_rd = s1_item_ff.sel ? ram_b_rdata : ram_a_rdata;
      // column zero of the newer row is kept aside when it is written
      center   = s1_item_ff.first_col ? row0_ff : ctr_ff;

      peak = (~s1_item_ff.has_up    | (older_rd      < center)) &
             (~s1_item_ff.has_down  | (s1_item_ff.down < center)) &
             (~s1_item_ff.has_left  | (lft_ff        < center)) &
             (~s1_item_ff.has_right | (newer_rd      < center));

      nb_up = s1_item_ff.has_up    ? older_rd        : '0;
      nb_dn = s1_item_ff.has_down  ? s1_item_ff.down : '0;
      nb_lf = s1_item_ff.has_left  ? lft_ff          : '0;
      nb_rt = s1_item_ff.has_right ? newer_rd        : '0;
      max_a = (nb_up > nb_dn) ? nb_up : nb_dn;
      max_b = (nb_lf > nb_rt) ? nb_lf : nb_rt;
      best  = (max_a > max_b) ? max_a : max_b;

      result  = peak ? best : center;
      s1_free = ~s1_valid_ff | ~rsp_valid_ff | rsp_ready;
      consume = s1_valid_ff & s1_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= item_valid;
         end
         if (consume && s1_item_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_item_ff <= item;
      end
      if (consume) begin
         ctr_ff <= newer_rd;
         lft_ff <= center;
         if (s1_item_ff.capture) begin
            row0_ff <= s1_item_ff.down;
         end
         if (s1_item_ff.emit) begin
            rsp_pixel_ff     <= result;
            rsp_row_end_ff   <= s1_item_ff.row_end;
            rsp_frame_end_ff <= s1_item_ff.frame_end;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

/* rtl/core/local_peak_clip_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_peak_clip_filter_unit
// 4-neighbor local maximum suppression on a raster stream, one row late.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         tdata: pixel_in, tuser: op (0 pixel, 1 drain)
//  rsp      out        tdata: pixel_out, tuser: row_end, tlast: frame_end
//  csr      in         index 0 image_width, index 1 image_height
//
//  one word per clock in, one per clock out while the output is not stalled
//  (registered line store read, then filter and output register)
//  the line stores are single port, read-first: older row read and
//  overwritten at the same column, newer row read one column ahead
//  req_tready drops only while a result waits in a full pipeline
//  synchronous reset clears counters and valids; line stores are not cleared
// ----------------------------------------------------------------------------
module local_peak_clip_filter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] pixel_in
   input  logic                               req_tuser,   // [0] op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] pixel_out
   output logic                               rsp_tuser,   // [0] row_end
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [lpcf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lpcf_pkg::CSR_BITS-1:0]      csr_wdata
);
   import lpcf_pkg::*;

   ram_req_type ram_a_req, ram_b_req;
   pixel_type   ram_a_rdata, ram_b_rdata;
   item_type    item;
   logic        item_valid;
   logic        s1_free;
   logic        accept;

   assign req_tready = s1_free;
   assign accept     = req_tvalid & s1_free;

   lpcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .req_op     (req_tuser),
      .req_pixel  (req_tdata[PIXEL_BITS-1:0]),
      .ram_a_req  (ram_a_req),
      .ram_b_req  (ram_b_req),
      .item_valid (item_valid),
      .item       (item)
   );

   lpcf_line_ram u_upper_ram (
      .clock (clock),
      .req   (ram_a_req),
      .rdata (ram_a_rdata)
   );

   lpcf_line_ram u_middle_ram (
      .clock (clock),
      .req   (ram_b_req),
      .rdata (ram_b_rdata)
   );

   lpcf_window u_window (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .ram_a_rdata   (ram_a_rdata),
      .ram_b_rdata   (ram_b_rdata),
      .s1_free       (s1_free),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_pixel     (rsp_tdata),
      .rsp_row_end   (rsp_tuser),
      .rsp_frame_end (rsp_tlast)
   );

`ifndef SYNTH
   // frame end always falls on a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end without row end");

   // input stalls only behind a blocked result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled while output free");

   // only the older row store is written, so never both stores at once
   assert property (@(posedge clock) disable iff (reset)
      !(ram_a_req.we && ram_b_req.we))
      else $error("both line stores written");

   // no store access without an accepted word
   assert property (@(posedge clock) disable iff (reset)
      ram_a_req.en || ram_b_req.en |-> accept)
      else $error("line store access without accept");
`endif

endmodule
